/* design/triangle_tangent_bitangent_core_macros.svh */
// ----------------------------------------------------------------------------
// triangle tangent/bitangent core assertion macros
// shared property shapes for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BITANGENT_CORE_MACROS_SVH
`define TRIANGLE_TANGENT_BITANGENT_CORE_MACROS_SVH

// same-cycle implication
`define TTB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ttb_pkg.sv */
// ----------------------------------------------------------------------------
// ttb_pkg
// types, codes and the product schedule of the tangent/bitangent core
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int FIELD_W    = 32;
  localparam int MAT_W      = 16;
  localparam int UNIT_W     = 16;
  localparam int CHUNK_W    = 16;
  localparam int SMALL_W    = 30;
  localparam int SUM_W      = 62;
  localparam int ROOT_W     = 63;
  localparam int LEN_W      = 32;
  localparam int ALIGN_STEP = 8;
  localparam int NUM_OPD    = 10;
  localparam int NUM_ACC    = 7;

  typedef logic [3:0] opd_idx_t;
  typedef logic [2:0] acc_idx_t;
  typedef logic [3:0] op_idx_t;

  // operand slots: uv deltas and edge vectors
  localparam opd_idx_t OPD_D1U = 4'd0;
  localparam opd_idx_t OPD_D1V = 4'd1;
  localparam opd_idx_t OPD_D2U = 4'd2;
  localparam opd_idx_t OPD_D2V = 4'd3;
  localparam opd_idx_t OPD_E1X = 4'd4;
  localparam opd_idx_t OPD_E1Y = 4'd5;
  localparam opd_idx_t OPD_E1Z = 4'd6;
  localparam opd_idx_t OPD_E2X = 4'd7;
  localparam opd_idx_t OPD_E2Y = 4'd8;
  localparam opd_idx_t OPD_E2Z = 4'd9;

  // accumulator slots
  localparam acc_idx_t ACC_DET = 3'd0;
  localparam acc_idx_t ACC_TX  = 3'd1;
  localparam acc_idx_t ACC_TY  = 3'd2;
  localparam acc_idx_t ACC_TZ  = 3'd3;
  localparam acc_idx_t ACC_BX  = 3'd4;
  localparam acc_idx_t ACC_BY  = 3'd5;
  localparam acc_idx_t ACC_BZ  = 3'd6;

  localparam op_idx_t LAST_OP = 4'd13;

  typedef struct packed {
    opd_idx_t a_sel;
    opd_idx_t b_sel;
    acc_idx_t dst;
    logic     sub;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_MUL,
    ST_CHECK,
    ST_NORM_T,
    ST_NORM_B
  } core_state_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_ALIGN,
    NS_SQUARE,
    NS_ROOT,
    NS_DIV_LOAD,
    NS_DIV_STEP
  } norm_state_t;

  // det, then t = d2v*e1 - d1v*e2, then b = d1u*e2 - d2u*e1
  function automatic op_t op_lookup(op_idx_t idx);
    op_t op;
    unique case (idx)
      4'd0:    op = '{OPD_D1U, OPD_D2V, ACC_DET, 1'b0};
      4'd1:    op = '{OPD_D2U, OPD_D1V, ACC_DET, 1'b1};
      4'd2:    op = '{OPD_D2V, OPD_E1X, ACC_TX,  1'b0};
      4'd3:    op = '{OPD_D1V, OPD_E2X, ACC_TX,  1'b1};
      4'd4:    op = '{OPD_D2V, OPD_E1Y, ACC_TY,  1'b0};
      4'd5:    op = '{OPD_D1V, OPD_E2Y, ACC_TY,  1'b1};
      4'd6:    op = '{OPD_D2V, OPD_E1Z, ACC_TZ,  1'b0};
      4'd7:    op = '{OPD_D1V, OPD_E2Z, ACC_TZ,  1'b1};
      4'd8:    op = '{OPD_D1U, OPD_E2X, ACC_BX,  1'b0};
      4'd9:    op = '{OPD_D2U, OPD_E1X, ACC_BX,  1'b1};
      4'd10:   op = '{OPD_D1U, OPD_E2Y, ACC_BY,  1'b0};
      4'd11:   op = '{OPD_D2U, OPD_E1Y, ACC_BY,  1'b1};
      4'd12:   op = '{OPD_D1U, OPD_E2Z, ACC_BZ,  1'b0};
      4'd13:   op = '{OPD_D2U, OPD_E1Z, ACC_BZ,  1'b1};
      default: op = '{OPD_D1U, OPD_D1U, ACC_DET, 1'b0};
    endcase
    return op;
  endfunction

endpackage

/* design/ttb_ifs.sv */
// ----------------------------------------------------------------------------
// ttb channel interfaces
// corner input channel and face result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface ttb_corner_if import ttb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] pos_x;
  logic signed [FIELD_W-1:0] pos_y;
  logic signed [FIELD_W-1:0] pos_z;
  logic signed [FIELD_W-1:0] tex_u;
  logic signed [FIELD_W-1:0] tex_v;
  logic                      has_texcoord;
  logic [MAT_W-1:0]          material_index;

  modport source (
    output valid, pos_x, pos_y, pos_z, tex_u, tex_v, has_texcoord, material_index,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, tex_u, tex_v, has_texcoord, material_index,
    output ready
  );
endinterface

interface ttb_face_if import ttb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [UNIT_W-1:0] tangent_x;
  logic signed [UNIT_W-1:0] tangent_y;
  logic signed [UNIT_W-1:0] tangent_z;
  logic signed [UNIT_W-1:0] bitangent_x;
  logic signed [UNIT_W-1:0] bitangent_y;
  logic signed [UNIT_W-1:0] bitangent_z;
  logic [MAT_W-1:0]         face_material;
  logic                     has_tangent;
  logic                     degenerate;

  modport source (
    output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
           bitangent_z, face_material, has_tangent, degenerate,
    input  ready
  );
  modport sink (
    input  valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
           bitangent_z, face_material, has_tangent, degenerate,
    output ready
  );
endinterface

/* design/ttb_mul.sv */
// ----------------------------------------------------------------------------
// ttb_mul
// serial unsigned multiplier, one 16-bit digit of b per cycle, msb first
// ----------------------------------------------------------------------------
module ttb_mul
  import ttb_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic               done,
  output logic [2*WIDTH-1:0] product
);

  localparam int NCH = (WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int BW  = NCH * CHUNK_W;
  localparam int PW  = WIDTH + BW;
  localparam int CCW = $clog2(NCH + 1);

  logic [WIDTH-1:0]         a_q;
  logic [BW-1:0]            b_q;
  logic [PW-1:0]            acc;
  logic [CCW-1:0]           cnt;
  logic                     busy;
  logic [WIDTH+CHUNK_W-1:0] part;

  assign part    = a_q * b_q[BW-1 -: CHUNK_W];
  assign product = acc[2*WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CCW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CCW'(NCH);
      end else if (busy) begin
        cnt <= cnt - CCW'(1);
        if (cnt == CCW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= BW'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << CHUNK_W) + PW'(part);
      b_q <= b_q << CHUNK_W;
    end
  end

endmodule

/* design/ttb_norm.sv */
// ----------------------------------------------------------------------------
// ttb_norm
// vector normalizer: align, sum of squares, bit-serial root and divide
// ----------------------------------------------------------------------------
module ttb_norm
  import ttb_pkg::*;
#(
  parameter int ACC_W = 66,
  parameter int FRAC  = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    flip,
  input  logic signed [ACC_W-1:0] vec [3],
  output logic                    done,
  output logic [UNIT_W-1:0]       res [3]
);

  localparam int MW  = ACC_W - 1;
  localparam int QB  = FRAC + 2;
  localparam int NW  = SMALL_W + FRAC + 1;
  localparam int QCW = $clog2(QB + 1);
  localparam int QW  = (QB > UNIT_W) ? QB : UNIT_W;

  norm_state_t        state;
  norm_state_t        state_next;
  logic [MW-1:0]      mag [3];
  logic               neg [3];
  logic [SMALL_W-1:0] small_mag [3];
  logic [1:0]         idx;
  logic [SUM_W-1:0]   s;
  logic [SUM_W-1:0]   s_sum;
  logic [ROOT_W-1:0]  x;
  logic [ROOT_W-1:0]  r;
  logic [ROOT_W-1:0]  r_next;
  logic [ROOT_W-1:0]  rbit;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W:0]     rem2;
  logic [QB-1:0]      nlo;
  logic [QB-1:0]      q;
  logic [QB-1:0]      qn;
  logic [QW-1:0]      qx;
  logic [QCW-1:0]     cnt;
  logic [NW-1:0]      num;
  logic [MW-1:0]      mag_or;
  logic [ROOT_W-1:0]  cs_lhs;
  logic [ROOT_W-1:0]  cs_rhs;
  logic [ROOT_W:0]    cs_diff;
  logic               cs_ge;

  assign mag_or = mag[0] | mag[1] | mag[2];
  assign s_sum  = s + SUM_W'(small_mag[idx] * small_mag[idx]);
  assign rem2   = {rem, nlo[QB-1]};
  assign num    = (NW'(small_mag[idx]) << FRAC) + NW'(len >> 1);

  // one compare-subtract serves both the root and the divide
  always_comb begin
    if (state == NS_ROOT) begin
      cs_lhs = x;
      cs_rhs = r + rbit;
    end else begin
      cs_lhs = ROOT_W'(rem2);
      cs_rhs = ROOT_W'(len);
    end
    cs_diff = {1'b0, cs_lhs} - {1'b0, cs_rhs};
    cs_ge   = !cs_diff[ROOT_W];
  end

  assign r_next = cs_ge ? ((r >> 1) + rbit) : (r >> 1);
  assign qn     = {q[QB-2:0], cs_ge};
  assign qx     = QW'(qn);

  always_comb begin
    state_next = state;
    unique case (state)
      NS_IDLE:     if (start) state_next = NS_ALIGN;
      NS_ALIGN:    if (mag_or[MW-1]) state_next = NS_SQUARE;
      NS_SQUARE:   if (idx == 2'd2) state_next = NS_ROOT;
      NS_ROOT:     if (rbit[0]) state_next = NS_DIV_LOAD;
      NS_DIV_LOAD: state_next = NS_DIV_STEP;
      NS_DIV_STEP: begin
        if (cnt == QCW'(1)) begin
          state_next = (idx == 2'd2) ? NS_IDLE : NS_DIV_LOAD;
        end
      end
      default:     state_next = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == NS_DIV_STEP) && (cnt == QCW'(1)) && (idx == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      NS_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= MW'(vec[i][ACC_W-1] ? -vec[i] : vec[i]);
            neg[i] <= vec[i][ACC_W-1] ^ flip;
          end
        end
      end
      NS_ALIGN: begin
        // common left shift until the largest magnitude reaches the top bit
        if (mag_or[MW-1]) begin
          for (int i = 0; i < 3; i++) begin
            small_mag[i] <= mag[i][MW-1 -: SMALL_W];
          end
          idx <= 2'd0;
          s   <= '0;
        end else if (mag_or[MW-1 -: ALIGN_STEP] == '0) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] << ALIGN_STEP;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] << 1;
          end
        end
      end
      NS_SQUARE: begin
        s    <= s_sum;
        idx  <= 2'(idx + 2'd1);
        x    <= ROOT_W'(s_sum);
        r    <= '0;
        rbit <= ROOT_W'(1) << (ROOT_W - 1);
      end
      NS_ROOT: begin
        if (cs_ge) begin
          x <= cs_diff[ROOT_W-1:0];
        end
        r    <= r_next;
        rbit <= rbit >> 2;
        if (rbit[0]) begin
          idx <= 2'd0;
          len <= (r_next == '0) ? LEN_W'(1) : LEN_W'(r_next);
        end
      end
      NS_DIV_LOAD: begin
        rem <= LEN_W'(num >> QB);
        nlo <= num[QB-1:0];
        q   <= '0;
        cnt <= QCW'(QB);
      end
      NS_DIV_STEP: begin
        rem <= cs_ge ? LEN_W'(cs_diff) : LEN_W'(rem2);
        q   <= qn;
        nlo <= nlo << 1;
        cnt <= cnt - QCW'(1);
        if (cnt == QCW'(1)) begin
          res[idx] <= UNIT_W'(neg[idx] ? -qx : qx);
          idx      <= 2'(idx + 2'd1);
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/triangle_tangent_bitangent_core.sv */
// ----------------------------------------------------------------------------
// triangle tangent/bitangent core
// per-triangle unit tangent and bitangent from corner positions and uvs
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  corner   | in  | valid/ready  | pos_x/y/z, tex_u/v, has_texcoord, material_index
//  face     | out | valid/ready  | tangent/bitangent x/y/z, face_material, flags
//
//  first two corners of a triangle are held in registers
//  third corner: 14 serial products, then per vector the align, square, root
//  and divide steps
//  no texcoord: result in the cycle after the third corner
//  rst clears the corner count and flags; corner.ready is low while a triangle
//  is computed or while a finished result waits and a third corner arrives
// ----------------------------------------------------------------------------
`include "triangle_tangent_bitangent_core_macros.svh"

module triangle_tangent_bitangent_core
  import ttb_pkg::*;
#(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst,
  ttb_corner_if.sink corner,
  ttb_face_if.source face
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int ACC_W = 2 * CW + 2;

  function automatic logic [CW-1:0] raw(logic [FIELD_W-1:0] f);
    return CW'(f);
  endfunction

  function automatic logic signed [DW-1:0] ext(logic [CW-1:0] v);
    return signed'({v[CW-1], v});
  endfunction

  core_state_t              state;
  core_state_t              state_next;
  logic [1:0]               corner_count;
  logic                     first_has_texcoord;
  logic [MAT_W-1:0]         held_material;
  logic [CW-1:0]            held_pos [2][3];
  logic [CW-1:0]            held_tex [2][2];
  logic [CW-1:0]            cur_pos [3];
  logic [CW-1:0]            cur_tex [2];
  logic signed [DW-1:0]     diff [NUM_OPD];
  logic [CW-1:0]            opd_mag [NUM_OPD];
  logic                     opd_neg [NUM_OPD];
  logic signed [ACC_W-1:0]  acc [NUM_ACC];
  op_idx_t                  op_idx;
  op_t                      op;
  opd_idx_t                 rd_idx;
  logic [CW-1:0]            a_mag;
  logic                     a_neg;
  logic                     prod_neg;
  logic                     mul_start;
  logic                     mul_done;
  logic [2*CW-1:0]          mul_product;
  logic signed [ACC_W-1:0]  prod_ext;
  logic                     norm_start;
  logic                     norm_done;
  logic [UNIT_W-1:0]        norm_res [3];
  logic signed [ACC_W-1:0]  norm_vec [3];
  logic                     flat;
  logic                     corner_ready;
  logic                     corner_fire;
  logic                     face_valid;
  logic [UNIT_W-1:0]        res_tangent [3];
  logic [UNIT_W-1:0]        res_bitangent [3];
  logic [MAT_W-1:0]         res_material;
  logic                     res_has_tangent;
  logic                     res_degenerate;

  assign op          = op_lookup(op_idx);
  assign rd_idx      = (state == ST_LOAD_A) ? op.a_sel : op.b_sel;
  assign corner_fire = corner.valid && corner_ready;
  assign corner.ready = corner_ready;
  assign prod_ext    = signed'(ACC_W'(mul_product));

  assign flat = (acc[ACC_DET] == '0) ||
                (acc[ACC_TX] == '0 && acc[ACC_TY] == '0 && acc[ACC_TZ] == '0) ||
                (acc[ACC_BX] == '0 && acc[ACC_BY] == '0 && acc[ACC_BZ] == '0);

  always_comb begin
    cur_pos[0] = raw(corner.pos_x);
    cur_pos[1] = raw(corner.pos_y);
    cur_pos[2] = raw(corner.pos_z);
    cur_tex[0] = raw(corner.tex_u);
    cur_tex[1] = raw(corner.tex_v);
    diff[OPD_D1U] = ext(held_tex[1][0]) - ext(held_tex[0][0]);
    diff[OPD_D1V] = ext(held_tex[1][1]) - ext(held_tex[0][1]);
    diff[OPD_D2U] = ext(cur_tex[0]) - ext(held_tex[0][0]);
    diff[OPD_D2V] = ext(cur_tex[1]) - ext(held_tex[0][1]);
    for (int i = 0; i < 3; i++) begin
      diff[opd_idx_t'(OPD_E1X + i)] = ext(held_pos[1][i]) - ext(held_pos[0][i]);
      diff[opd_idx_t'(OPD_E2X + i)] = ext(cur_pos[i]) - ext(held_pos[0][i]);
    end
  end

  // tangent first, then bitangent; the sign of det flips both
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_vec[i] = (state == ST_CHECK) ? acc[acc_idx_t'(ACC_TX + i)]
                                        : acc[acc_idx_t'(ACC_BX + i)];
    end
  end

  always_comb begin
    state_next   = state;
    corner_ready = 1'b0;
    mul_start    = 1'b0;
    norm_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        corner_ready = !(corner_count == 2'd2 && face_valid);
        if (corner_fire && corner_count == 2'd2 && first_has_texcoord) begin
          state_next = ST_LOAD_A;
        end
      end
      ST_LOAD_A: state_next = ST_LOAD_B;
      ST_LOAD_B: begin
        mul_start  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = (op_idx == LAST_OP) ? ST_CHECK : ST_LOAD_A;
        end
      end
      ST_CHECK: begin
        if (flat) begin
          state_next = ST_IDLE;
        end else begin
          norm_start = 1'b1;
          state_next = ST_NORM_T;
        end
      end
      ST_NORM_T: begin
        if (norm_done) begin
          norm_start = 1'b1;
          state_next = ST_NORM_B;
        end
      end
      ST_NORM_B: if (norm_done) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      corner_count       <= 2'd0;
      first_has_texcoord <= 1'b0;
      held_material      <= '0;
      face_valid         <= 1'b0;
      op_idx             <= '0;
    end else begin
      state <= state_next;
      if (face_valid && face.ready) begin
        face_valid <= 1'b0;
      end
      if (corner_fire) begin
        if (corner_count == 2'd2) begin
          corner_count <= 2'd0;
          op_idx       <= '0;
          if (!first_has_texcoord) begin
            face_valid <= 1'b1;
          end
        end else begin
          corner_count <= 2'(corner_count + 2'd1);
          if (corner_count == 2'd0) begin
            first_has_texcoord <= corner.has_texcoord;
            held_material      <= corner.material_index;
          end
        end
      end
      if (state == ST_MUL && mul_done) begin
        op_idx <= op_idx_t'(op_idx + 4'd1);
      end
      if (state == ST_CHECK && flat) begin
        face_valid <= 1'b1;
      end
      if (state == ST_NORM_B && norm_done) begin
        face_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (corner_fire) begin
      if (corner_count != 2'd2) begin
        for (int i = 0; i < 3; i++) begin
          held_pos[corner_count[0]][i] <= cur_pos[i];
        end
        held_tex[corner_count[0]][0] <= cur_tex[0];
        held_tex[corner_count[0]][1] <= cur_tex[1];
      end else begin
        for (int i = 0; i < NUM_OPD; i++) begin
          opd_mag[i] <= CW'(diff[i][DW-1] ? -diff[i] : diff[i]);
          opd_neg[i] <= diff[i][DW-1];
        end
        for (int i = 0; i < NUM_ACC; i++) begin
          acc[i] <= '0;
        end
        res_material    <= held_material;
        res_has_tangent <= first_has_texcoord;
        if (!first_has_texcoord) begin
          for (int i = 0; i < 3; i++) begin
            res_tangent[i]   <= '0;
            res_bitangent[i] <= '0;
          end
          res_degenerate <= 1'b0;
        end
      end
    end
    if (state == ST_LOAD_A) begin
      a_mag <= opd_mag[rd_idx];
      a_neg <= opd_neg[rd_idx];
    end
    if (state == ST_LOAD_B) begin
      prod_neg <= a_neg ^ opd_neg[rd_idx] ^ op.sub;
    end
    if (state == ST_MUL && mul_done) begin
      acc[op.dst] <= prod_neg ? (acc[op.dst] - prod_ext) : (acc[op.dst] + prod_ext);
    end
    if (state == ST_CHECK && flat) begin
      for (int i = 0; i < 3; i++) begin
        res_tangent[i]   <= '0;
        res_bitangent[i] <= '0;
      end
      res_degenerate <= 1'b1;
    end
    if (state == ST_NORM_T && norm_done) begin
      res_tangent <= norm_res;
    end
    if (state == ST_NORM_B && norm_done) begin
      res_bitangent  <= norm_res;
      res_degenerate <= 1'b0;
    end
  end

  ttb_mul #(
    .WIDTH (CW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (a_mag),
    .b       (opd_mag[rd_idx]),
    .done    (mul_done),
    .product (mul_product)
  );

  ttb_norm #(
    .ACC_W (ACC_W),
    .FRAC  (UNIT_FRAC_BITS)
  ) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .flip  (acc[ACC_DET][ACC_W-1]),
    .vec   (norm_vec),
    .done  (norm_done),
    .res   (norm_res)
  );

  assign face.valid         = face_valid;
  assign face.tangent_x     = res_tangent[0];
  assign face.tangent_y     = res_tangent[1];
  assign face.tangent_z     = res_tangent[2];
  assign face.bitangent_x   = res_bitangent[0];
  assign face.bitangent_y   = res_bitangent[1];
  assign face.bitangent_z   = res_bitangent[2];
  assign face.face_material = res_material;
  assign face.has_tangent   = res_has_tangent;
  assign face.degenerate    = res_degenerate;

  `TTB_ASSERT_IMP(a_degen_needs_tex, clk, rst, face_valid && res_degenerate, res_has_tangent, "degenerate without texcoord")
  `TTB_ASSERT_IMP(a_no_tex_zero, clk, rst, face_valid && !res_has_tangent, res_tangent[0] == '0 && res_bitangent[0] == '0, "vectors not zero without texcoord")
  `TTB_ASSERT_IMP(a_busy_count, clk, rst, state != ST_IDLE, corner_count == 2'd0, "corner count not cleared while computing")
  `TTB_ASSERT_IMP(a_mul_done_state, clk, rst, mul_done, state == ST_MUL, "product finished outside multiply state")
  `TTB_ASSERT_NXT(a_norm_b_result, clk, rst, state == ST_NORM_B && norm_done, face_valid, "bitangent done without result")

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// corner stream against the tangent/bitangent core, faces checked on the fly
// ----------------------------------------------------------------------------
module tb_top;
  import ttb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] px, py, pz, tu, tv;
    logic               htc;
    logic [15:0]        mat;
  } corner_t;

  typedef struct {
    logic [15:0] tx, ty, tz, bx, by, bz;
    logic [15:0] mat;
    logic        htc, degen;
  } face_t;

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  ttb_corner_if corner();
  ttb_face_if   face();

  triangle_tangent_bitangent_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .corner(corner.sink),
    .face  (face.source)
  );

  corner_t pending_corners[$];
  face_t   expected_faces[$];
  corner_t held[2];
  int      corner_idx = 0;
  int      errors = 0;
  int      quiet_cycles = 0;
  bit      stim_done = 0;
  bit      calm = 0;

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // align largest magnitude to [2^29, 2^30), then round-divide by the length
  function automatic void normalize(input logic signed [127:0] v[3],
                                    output logic [15:0] q[3]);
    logic [127:0] mag[3];
    logic [63:0]  sm[3];
    logic [63:0]  s, len, m;
    int n, bl;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      bl = 0;
      for (int k = 0; k < 128; k++) if (mag[i][k]) bl = k + 1;
      if (bl > n) n = bl;
    end
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if (n > 30) sm[i] = 64'(mag[i] >> (n - 30));
      else sm[i] = 64'(mag[i] << (30 - n));
      sm[i] = sm[i] & 64'h3FFF_FFFF;
      s = s + sm[i] * sm[i];
    end
    len = isqrt(s);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      m = ((sm[i] << 14) + (len >> 1)) / len;
      q[i] = v[i] < 0 ? 16'(-m) : 16'(m);
    end
  endfunction

  task automatic predict_face(corner_t c);
    logic signed [127:0] d1u, d1v, d2u, d2v, det, e1[3], e2[3], tv[3], bv[3];
    logic [15:0] qt[3], qb[3];
    face_t f;
    if (corner_idx < 2) begin
      held[corner_idx] = c;
      corner_idx++;
      return;
    end
    corner_idx = 0;
    qt = '{0, 0, 0};
    qb = '{0, 0, 0};
    f.degen = 0;
    if (held[0].htc) begin
      d1u = 128'(held[1].tu) - 128'(held[0].tu);
      d1v = 128'(held[1].tv) - 128'(held[0].tv);
      d2u = 128'(c.tu) - 128'(held[0].tu);
      d2v = 128'(c.tv) - 128'(held[0].tv);
      det = d1u * d2v - d2u * d1v;
      e1[0] = 128'(held[1].px) - 128'(held[0].px);
      e1[1] = 128'(held[1].py) - 128'(held[0].py);
      e1[2] = 128'(held[1].pz) - 128'(held[0].pz);
      e2[0] = 128'(c.px) - 128'(held[0].px);
      e2[1] = 128'(c.py) - 128'(held[0].py);
      e2[2] = 128'(c.pz) - 128'(held[0].pz);
      for (int i = 0; i < 3; i++) begin
        tv[i] = d2v * e1[i] - d1v * e2[i];
        bv[i] = d1u * e2[i] - d2u * e1[i];
        if (det < 0) begin
          tv[i] = -tv[i];
          bv[i] = -bv[i];
        end
      end
      if (det == 0 || (tv[0] == 0 && tv[1] == 0 && tv[2] == 0) ||
          (bv[0] == 0 && bv[1] == 0 && bv[2] == 0)) begin
        f.degen = 1;
      end else begin
        normalize(tv, qt);
        normalize(bv, qb);
      end
    end
    f.tx = qt[0]; f.ty = qt[1]; f.tz = qt[2];
    f.bx = qb[0]; f.by = qb[1]; f.bz = qb[2];
    f.mat = held[0].mat;
    f.htc = held[0].htc;
    expected_faces.push_back(f);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 0);
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic corner_t rand_corner(bit htc);
    corner_t c;
    c.px = rand_coord(); c.py = rand_coord(); c.pz = rand_coord();
    c.tu = rand_coord(); c.tv = rand_coord();
    c.htc = htc;
    c.mat = $urandom();
    return c;
  endfunction

  function automatic corner_t mk(int x, int y, int z, int u, int v, bit h, int m);
    corner_t c;
    c.px = x; c.py = y; c.pz = z; c.tu = u; c.tv = v; c.htc = h; c.mat = m;
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      corner.valid <= 0;
    end else if (!corner.valid || corner.ready) begin
      if (pending_corners.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
        corner_t c;
        c = pending_corners.pop_front();
        corner.valid          <= 1;
        corner.pos_x          <= c.px;
        corner.pos_y          <= c.py;
        corner.pos_z          <= c.pz;
        corner.tex_u          <= c.tu;
        corner.tex_v          <= c.tv;
        corner.has_texcoord   <= c.htc;
        corner.material_index <= c.mat;
      end else begin
        corner.valid <= 0;
      end
    end
  end

  // monitor and sink stalls
  always @(posedge clk) begin
    if (rst) begin
      face.ready <= 0;
    end else begin
      face.ready <= calm || $urandom_range(0, 99) >= 12;
      if (corner.valid && corner.ready) begin
        corner_t c;
        c.px = corner.pos_x; c.py = corner.pos_y; c.pz = corner.pos_z;
        c.tu = corner.tex_u; c.tv = corner.tex_v;
        c.htc = corner.has_texcoord; c.mat = corner.material_index;
        predict_face(c);
      end
      if ((corner.valid && corner.ready) || (face.valid && face.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (face.valid && face.ready) begin
        if (expected_faces.size() == 0) begin
          $error("face transaction with nothing expected");
          errors++;
        end else begin
          face_t e;
          e = expected_faces.pop_front();
          if (face.tangent_x !== e.tx) begin
            $error("tangent_x exp %h got %h", e.tx, face.tangent_x); errors++; end
          if (face.tangent_y !== e.ty) begin
            $error("tangent_y exp %h got %h", e.ty, face.tangent_y); errors++; end
          if (face.tangent_z !== e.tz) begin
            $error("tangent_z exp %h got %h", e.tz, face.tangent_z); errors++; end
          if (face.bitangent_x !== e.bx) begin
            $error("bitangent_x exp %h got %h", e.bx, face.bitangent_x); errors++; end
          if (face.bitangent_y !== e.by) begin
            $error("bitangent_y exp %h got %h", e.by, face.bitangent_y); errors++; end
          if (face.bitangent_z !== e.bz) begin
            $error("bitangent_z exp %h got %h", e.bz, face.bitangent_z); errors++; end
          if (face.face_material !== e.mat) begin
            $error("face_material exp %h got %h", e.mat, face.face_material); errors++; end
          if (face.has_tangent !== e.htc) begin
            $error("has_tangent exp %b got %b", e.htc, face.has_tangent); errors++; end
          if (face.degenerate !== e.degen) begin
            $error("degenerate exp %b got %b", e.degen, face.degenerate); errors++; end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int one;
    one = 32'h0001_0000;
    corner.valid = 0;
    corner.pos_x = 0; corner.pos_y = 0; corner.pos_z = 0;
    corner.tex_u = 0; corner.tex_v = 0;
    corner.has_texcoord = 0; corner.material_index = 0;
    face.ready = 0;
    // directed: simple frame, flipped winding, zero det, zero vector, extreme coordinates, no uv
    pending_corners.push_back(mk(0, 0, 0, 0, 0, 1, 16'h0001));
    pending_corners.push_back(mk(one, 0, 0, one, 0, 0, 0));
    pending_corners.push_back(mk(0, one, 0, 0, one, 0, 0));
    pending_corners.push_back(mk(0, 0, 0, 0, 0, 1, 16'hFFFF));
    pending_corners.push_back(mk(one, 0, 0, 0, one, 1, 0));
    pending_corners.push_back(mk(0, 0, one, one, 0, 1, 0));
    pending_corners.push_back(mk(5, 6, 7, 3, 3, 1, 16'h1234));
    pending_corners.push_back(mk(9, 1, 2, 3, 3, 1, 0));
    pending_corners.push_back(mk(4, 4, 4, 3, 3, 1, 0));
    pending_corners.push_back(mk(7, 7, 7, 0, 0, 1, 16'h00FF));
    pending_corners.push_back(mk(7, 7, 7, one, 0, 1, 0));
    pending_corners.push_back(mk(7, 7, 7, 0, one, 1, 0));
    pending_corners.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h8000_0000, 1, 16'hA5A5));
    pending_corners.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h8000_0000, 0, 16'hFFFF));
    pending_corners.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 16'hFFFF));
    pending_corners.push_back(mk(-1, -1, -1, -1, -1, 0, 16'h5A5A));
    pending_corners.push_back(mk(one, 2, 3, 4, 5, 1, 0));
    pending_corners.push_back(mk(6, 7, 8, 9, 10, 1, 0));
    for (int t = 0; t < 670; t++) begin
      bit h;
      h = $urandom_range(0, 9) != 0;
      for (int k = 0; k < 3; k++)
        pending_corners.push_back(rand_corner(k == 0 ? h : $urandom_range(0, 1)));
    end
    repeat (5) @(posedge clk);
    rst <= 0;
    while (pending_corners.size() != 0) begin
      @(posedge clk);
      calm <= pending_corners.size() < 600 && pending_corners.size() > 300;
    end
    while (corner.valid || expected_faces.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_faces.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
